@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files; sha_control.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An implication that must hold at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// A condition that must hold at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) else $error("assertion failed");

`endif

@@ rtl/sha_pkg.sv @@
package sha_pkg;

    localparam int unsigned NumRounds = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic pad_mark;
        logic pad_byte;
        logic pad_len;
        logic start_block;
        logic round_step;
        logic fold;
        logic reload;
    } cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } status_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[i];
    endfunction

    function automatic logic [31:0] initial_chain(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        return h[i];
    endfunction

endpackage

@@ rtl/sha_datapath.sv @@
module sha_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  sha_pkg::cmd_t      cmd,
    input  logic [7:0]         byte_in,
    output sha_pkg::status_t   status,
    output logic [31:0]        chain_word,
    input  logic [2:0]         chain_sel
);

    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [31:0] h_reg [8];
    logic [31:0] r_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;

    logic [7:0]  wr_byte;
    logic        wr_en;
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s0;
    logic [31:0] s1;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Bytes are shifted into the message schedule window in arrival order, so
    // after 64 writes word 0 holds bytes 0 to 3 big-endian.
    always_comb begin
        wr_en   = cmd.load_byte || cmd.pad_mark || cmd.pad_byte;
        wr_byte = byte_in;
        if (cmd.pad_mark) begin
            wr_byte = 8'h80;
        end else if (cmd.pad_byte) begin
            wr_byte = 8'h00;
            if (cmd.pad_len && fill_reg >= 6'd56) begin
                wr_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
            end
        end
    end

    always_comb begin
        s0    = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        t1 = r_reg[7] + (ror(r_reg[4], 6) ^ ror(r_reg[4], 11) ^ ror(r_reg[4], 25))
             + ((r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]))
             + sha_pkg::round_const(rnd_reg) + w_cur;
        t2 = (ror(r_reg[0], 2) ^ ror(r_reg[0], 13) ^ ror(r_reg[0], 22))
             + ((r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_reg[15] <= {w_reg[15][23:0], wr_byte};
        end else if (cmd.round_step) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
        if (cmd.start_block) begin
            for (int i = 0; i < 8; i++) begin
                r_reg[i] <= h_reg[i];
            end
        end else if (cmd.round_step) begin
            r_reg[7] <= r_reg[6];
            r_reg[6] <= r_reg[5];
            r_reg[5] <= r_reg[4];
            r_reg[4] <= r_reg[3] + t1;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= r_reg[1];
            r_reg[1] <= r_reg[0];
            r_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reload) begin
            fill_reg <= '0;
            bits_reg <= '0;
            rnd_reg  <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha_pkg::initial_chain(3'(i));
            end
        end else begin
            if (cmd.load_byte) begin
                bits_reg <= bits_reg + 64'd8;
            end
            if (wr_en) begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.start_block) begin
                rnd_reg <= '0;
            end else if (cmd.round_step) begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + r_reg[i];
                end
            end
        end
    end

    assign status.fill       = fill_reg;
    assign status.round_last = (rnd_reg == 6'(sha_pkg::NumRounds - 1));
    assign chain_word        = h_reg[chain_sel];

endmodule

@@ rtl/sha_control.sv @@
`include "assert_macros.svh"

module sha_control (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_has_byte,
    input  logic              s_end_of_message,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_word_number,
    output logic              m_last_word,
    output sha_pkg::cmd_t     cmd,
    input  sha_pkg::status_t  status
);

    sha_pkg::state_t state_reg, state_next;
    logic            final_reg, final_next;
    logic            padding_reg, padding_next;
    logic            extra_reg, extra_next;
    logic [2:0]      word_reg, word_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sha_pkg::ST_IDLE;
            final_reg   <= 1'b0;
            padding_reg <= 1'b0;
            extra_reg   <= 1'b0;
            word_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            final_reg   <= final_next;
            padding_reg <= padding_next;
            extra_reg   <= extra_next;
            word_reg    <= word_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        final_next   = final_reg;
        padding_next = padding_reg;
        extra_next   = extra_reg;
        word_next    = word_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_byte = s_has_byte;
                    final_next    = s_end_of_message;
                    padding_next  = 1'b0;
                    extra_next    = 1'b0;
                    if (s_has_byte && status.fill == 6'd63) begin
                        state_next = sha_pkg::ST_ROUND;
                    end else if (s_end_of_message) begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                // When the marker byte lands in the last eight places, the
                // length goes into an extra block of its own.
                if (!padding_reg) begin
                    cmd.pad_mark = 1'b1;
                    padding_next = 1'b1;
                    extra_next   = (status.fill >= 6'd56);
                end else begin
                    cmd.pad_byte = 1'b1;
                    cmd.pad_len  = !extra_reg;
                end
                if (status.fill == 6'd63) begin
                    state_next = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND: begin
                cmd.round_step = 1'b1;
                if (status.round_last) begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD: begin
                cmd.fold = 1'b1;
                if (!final_reg) begin
                    state_next = sha_pkg::ST_IDLE;
                end else if (!padding_reg) begin
                    state_next = sha_pkg::ST_PAD;
                end else if (extra_reg) begin
                    extra_next = 1'b0;
                    state_next = sha_pkg::ST_PAD;
                end else begin
                    state_next = sha_pkg::ST_EMIT;
                end
            end
            sha_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == 3'd7) begin
                        cmd.reload = 1'b1;
                        final_next = 1'b0;
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
        // The round registers load from the chain on the cycle that enters the rounds.
        if (state_next == sha_pkg::ST_ROUND && state_reg != sha_pkg::ST_ROUND) begin
            cmd.start_block = 1'b1;
        end
    end

    assign m_word_number = word_reg;
    assign m_last_word   = (word_reg == 3'd7);

    `ASSERT_IMPL(a_ready_idle, aclk, aresetn,
        s_ready == (state_reg == sha_pkg::ST_IDLE))
    `ASSERT_IMPL(a_emit_fold, aclk, aresetn,
        (state_reg == sha_pkg::ST_EMIT && $past(state_reg) != sha_pkg::ST_EMIT)
        |-> $past(state_reg) == sha_pkg::ST_FOLD)
    `ASSERT_IMPL(a_word_zero, aclk, aresetn,
        (state_reg != sha_pkg::ST_EMIT) |-> word_reg == 3'd0)

endmodule

@@ rtl/sha256_byte_stream_hasher.sv @@
// SHA-256 over a byte stream. One byte is taken per transfer; each full
// 64-byte block then holds the input through the 64 rounds of the single
// round unit and the chain fold (the block start shares the cycle of the
// last byte). An end-of-message transfer pads one byte per cycle up to the block
// end, compresses (twice when more than 55 bytes are pending), and then offers
// the digest as eight transfers, word 0 first.
module sha256_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_msg_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_number,
    output logic        m_last_word
);

    sha_pkg::cmd_t    cmd;
    sha_pkg::status_t status;

    sha_control u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_has_byte       (s_has_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_word_number    (m_word_number),
        .m_last_word      (m_last_word),
        .cmd              (cmd),
        .status           (status)
    );

    sha_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .byte_in    (s_msg_byte),
        .status     (status),
        .chain_word (m_digest_word),
        .chain_sel  (m_word_number)
    );

endmodule
